// ===== hdl/msb_pkg.sv =====
package msb_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } in_t;

  typedef struct packed {
    data_t sorted_value;
    logic  final_res;
    logic  overflow;
  } out_t;

  // Broadcast to every cell in the same cycle.
  typedef struct packed {
    logic  insert;
    logic  shift;
    data_t value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic  valid;
    logic  gt;
    data_t val;
  } link_t;

endpackage

// ===== hdl/msb_cell.sv =====
module msb_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  msb_pkg::cmd_t cmd,
  input  msb_pkg::link_t left_link,
  input  msb_pkg::link_t right_link,
  output msb_pkg::link_t link
);

  logic          valid_r;
  logic          valid_nxt;
  msb_pkg::data_t val_r;
  msb_pkg::data_t val_nxt;
  logic          gt;

  // New word belongs at or before this slot.
  assign gt = !valid_r || (cmd.value < val_r);

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.val   = val_r;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    if (cmd.insert) begin
      if (gt) begin
        if (left_link.gt) begin
          // open a gap to the left: take the neighbor's word
          val_nxt   = left_link.val;
          valid_nxt = valid_r | left_link.valid;
        end else begin
          val_nxt   = cmd.value;
          valid_nxt = 1'b1;
        end
      end
    end else if (cmd.shift) begin
      val_nxt   = right_link.val;
      valid_nxt = right_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/merge_sort_bottom_up_core.sv =====
// Sorting block for sets of signed words, ascending order.
// Input channel (in_valid / in_stall / in_data): one word per cycle is taken
// while loading; the word flagged last closes the set. Each word is placed in
// its sorted position on arrival by a row of DEPTH compare-and-shift cells.
// After the last word the block drains: in_stall is high and the words leave
// on the output channel (out_valid / out_stall / out_data) from the head cell,
// one per cycle while out_stall is low, smallest first, final_res on the last
// one. One set is in flight at a time; the next set is taken once the last
// result leaves. Words beyond DEPTH are dropped and overflow is set on every
// result of that set. If the receiver raises out_stall, the head word holds
// and the drain pauses. Reset empties all cells and returns the block to
// loading; no clearing pass is needed.
module merge_sort_bottom_up_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  msb_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output msb_pkg::out_t out_data
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t         state_r;
  logic           dropped_r;
  logic           ovf_r;
  msb_pkg::cmd_t  cmd;
  msb_pkg::link_t links [msb_pkg::DEPTH];
  msb_pkg::link_t head_link;
  msb_pkg::link_t tail_link;
  logic [msb_pkg::DEPTH-1:0] valid_vec;
  logic           in_fire;
  logic           out_fire;
  logic           full;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign full      = links[msb_pkg::DEPTH-1].valid;
  assign out_valid = (state_r == ST_DRAIN) && links[0].valid;
  assign out_fire  = out_valid && !out_stall;

  assign cmd.insert = in_fire && !full;
  assign cmd.shift  = out_fire;
  assign cmd.value  = in_data.value;

  // Head never precedes a new word; tail feeds empties during drain.
  assign head_link.valid = 1'b1;
  assign head_link.gt    = 1'b0;
  assign head_link.val   = '0;
  assign tail_link.valid = 1'b0;
  assign tail_link.gt    = 1'b1;
  assign tail_link.val   = '0;

  for (genvar i = 0; i < msb_pkg::DEPTH; i++) begin : g_cell
    msb_pkg::link_t left_l;
    msb_pkg::link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = head_link;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == msb_pkg::DEPTH-1) begin : g_last
      assign right_l = tail_link;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    msb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_link  (left_l),
      .right_link (right_l),
      .link       (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  assign out_data.sorted_value = links[0].val;
  assign out_data.final_res    = !links[1].valid;
  assign out_data.overflow     = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (in_data.last) begin
              state_r   <= ST_DRAIN;
              ovf_r     <= dropped_r | full;
              dropped_r <= 1'b0;
            end else if (full) begin
              dropped_r <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          // leave once the final word is taken
          if (out_fire && !links[1].valid) begin
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // Occupied cells always form a contiguous run from the head.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("cell occupancy not contiguous");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && !in_data.last) |=> dropped_r)
    else $error("dropped word not flagged");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.final_res) |=> (state_r == ST_LOAD) && !links[0].valid)
    else $error("drain did not finish on final word");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last) |=> out_valid)
    else $error("set closed with no result");

endmodule
